>>> src/ctsrr_pkg.sv
// Shared types and constants for the capture timestamp round-robin core.
`timescale 1ns / 1ps

package ctsrr_pkg;

  // Fixed field widths.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned CAP_W    = 16;
  localparam int unsigned EXT_W    = 16;
  localparam int unsigned TS_W     = EXT_W + CAP_W;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned MAX_CH   = 4;

  // Action codes carried in a request.
  localparam logic [ACTION_W-1:0] ACT_CAPTURE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SERVICE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_EXT_CLEAR = 2'd2;

  // Reset value of the channel enable register and the capture high-nibble mask.
  localparam logic [MAX_CH-1:0] ENABLE_RESET = 4'hf;
  localparam logic [CAP_W-1:0]  HIGH_NIBBLE  = 16'hf000;

  // Input request payload.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [MAX_CH-1:0]   capture_flags;
    logic                wrap_pending;
    logic [CAP_W-1:0]    capture_zero;
    logic [CAP_W-1:0]    capture_one;
    logic [CAP_W-1:0]    capture_two;
    logic [CAP_W-1:0]    capture_three;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic              found;
    logic [CHAN_W-1:0] channel;
    logic              overwritten;
    logic [CNT_W-1:0]  event_count;
    logic [TS_W-1:0]   timestamp;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic ext_clear;
    logic scan_start;
    logic scan_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic last;
  } status_t;

endpackage

>>> src/ctsrr_ctrl.sv
// Controller state machine: request acceptance, scan sequencing and result hand-off.
`timescale 1ns / 1ps

module ctsrr_ctrl
  import ctsrr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [ACTION_W-1:0] req_action,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output cmd_t                cmd,
  input  status_t             status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state;

  // A request is taken only while idle.
  assign req_stall = (state != ST_IDLE);

  // Command decode.
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req_action)
            ACT_CAPTURE:   cmd.capture    = 1'b1;
            ACT_SERVICE:   cmd.scan_start = 1'b1;
            ACT_EXT_CLEAR: cmd.ext_clear  = 1'b1;
            default:       cmd            = '0;
          endcase
        end
      end
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_EMIT: cmd.load_out  = !rsp_valid || !rsp_stall;
      default: cmd = '0;
    endcase
  end

  // State and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid && (req_action == ACT_SERVICE)) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status.hit || status.last) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (cmd.load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/ctsrr_dpath.sv
// Datapath: channel records, timestamp extension, scan pointer and result register.
`timescale 1ns / 1ps

module ctsrr_dpath
  import ctsrr_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  req_t              req,
  input  logic              cfg_write,
  input  logic [MAX_CH-1:0] cfg_data,
  input  cmd_t              cmd,
  output status_t           status,
  output rsp_t              rsp
);

  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [MAX_CH-1:0]   channel_enable;
  logic [EXT_W-1:0]    extension_count;
  logic [TS_W-1:0]     channel_timestamp [NUM_CHANNELS];
  logic [CNT_W-1:0]    channel_count     [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] channel_valid;
  logic [NUM_CHANNELS-1:0] channel_overwrite;
  logic [CH_W-1:0]     service_pointer;
  logic [CH_W-1:0]     scan_steps;
  rsp_t                result;

  logic [CAP_W-1:0]    capture [MAX_CH];
  logic [MAX_CH-1:0]   capture_hit;
  logic [CH_W-1:0]     pointer_next;

  // Captured values and the enabled capture flags.
  assign capture[0]  = req.capture_zero;
  assign capture[1]  = req.capture_one;
  assign capture[2]  = req.capture_two;
  assign capture[3]  = req.capture_three;
  assign capture_hit = req.capture_flags & channel_enable;

  // Next channel to examine, wrapping at the channel count.
  assign pointer_next = (service_pointer == CH_W'(NUM_CHANNELS - 1)) ? '0
                                                                     : service_pointer + 1'b1;

  assign status.hit  = channel_valid[pointer_next];
  assign status.last = (scan_steps == CH_W'(NUM_CHANNELS - 2));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable <= ENABLE_RESET;
    end else if (cfg_write) begin
      channel_enable <= cfg_data;
    end
  end

  // Timestamp extension: a pending wrap advances it after the channels are stored.
  always_ff @(posedge clk) begin
    if (rst) begin
      extension_count <= '0;
    end else if (cmd.ext_clear) begin
      extension_count <= '0;
    end else if (cmd.capture && req.wrap_pending) begin
      extension_count <= extension_count + 1'b1;
    end
  end

  // Per-channel records: captures update them, a scan hit clears the flags.
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
    logic [EXT_W-1:0] ts_high;

    assign ts_high = extension_count +
                     EXT_W'(req.wrap_pending && ((capture[i] & HIGH_NIBBLE) == '0));

    always_ff @(posedge clk) begin
      if (rst) begin
        channel_valid[i]     <= 1'b0;
        channel_overwrite[i] <= 1'b0;
        channel_count[i]     <= '0;
      end else if (cmd.capture && capture_hit[i]) begin
        channel_valid[i]     <= 1'b1;
        channel_overwrite[i] <= channel_overwrite[i] | channel_valid[i];
        channel_count[i]     <= channel_count[i] + 1'b1;
      end else if (cmd.scan_step && status.hit && (pointer_next == CH_W'(i))) begin
        channel_valid[i]     <= 1'b0;
        channel_overwrite[i] <= 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.capture && capture_hit[i]) begin
        channel_timestamp[i] <= {ts_high, capture[i]};
      end
    end
  end

  // Scan pointer and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      service_pointer <= '0;
      scan_steps      <= '0;
    end else if (cmd.scan_start) begin
      scan_steps <= '0;
    end else if (cmd.scan_step) begin
      service_pointer <= pointer_next;
      scan_steps      <= scan_steps + 1'b1;
    end
  end

  // Scan result: zero unless a valid channel is met.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      result <= '0;
    end else if (cmd.scan_step && status.hit) begin
      result.found       <= 1'b1;
      result.channel     <= CHAN_W'(pointer_next);
      result.overwritten <= channel_overwrite[pointer_next];
      result.event_count <= channel_count[pointer_next];
      result.timestamp   <= channel_timestamp[pointer_next];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp <= result;
    end
  end

endmodule

>>> src/capture_timestamp_round_robin_core.sv
// Top level of the four-channel input-capture timestamp core.
//
//   Channel   Signals                       Direction   Handshake
//   request   req_valid, req_stall, req     in          valid / stall
//   result    rsp_valid, rsp_stall, rsp     out         valid / stall
//   config    cfg_valid, cfg_ready, cfg_data in         valid / ready
//
// A capture or extension-clear request completes in the cycle it is accepted.
// A service request runs one scan step per channel examined by the sequencer, then
// loads the result register.
// Reset is synchronous and clears the extension, flags, counts and pointer.
// A stalled result holds in the output register while new requests are taken; a
// service request still scans, then waits with the input stalled until it leaves.
`timescale 1ns / 1ps

module capture_timestamp_round_robin_core
  import ctsrr_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MAX_CH-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // The enable register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  ctsrr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_action (req.action),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .cmd        (cmd),
    .status     (status)
  );

  ctsrr_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .rsp       (rsp)
  );

endmodule
